// File: hdl/bounded_array_list_engine_top_macros.svh
// assertion macros for the bounded array list engine
`ifndef BOUNDED_ARRAY_LIST_ENGINE_TOP_MACROS_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked outside reset
`define BALE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define BALE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BALE_ASSERT(lbl, prop, msg)
`define BALE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: hdl/bale_pkg.sv
// shared types and constants of the bounded array list engine
package bale_pkg;

  localparam int CAPACITY = 8;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int FUNC_W  = 4;
  localparam int WORD_W  = 32;
  localparam int POS_W   = 4;
  localparam int AMT_W   = 8;
  localparam int STEP_W  = $clog2(AMT_W);
  localparam int STAT_W  = 3;
  localparam int INDEX_W = 3;
  localparam int COUNT_W = 4;
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  // request codes
  localparam logic [FUNC_W-1:0] FN_INS_END   = 4'd0;
  localparam logic [FUNC_W-1:0] FN_INS_FRONT = 4'd1;
  localparam logic [FUNC_W-1:0] FN_INS_POS   = 4'd2;
  localparam logic [FUNC_W-1:0] FN_DEL_END   = 4'd3;
  localparam logic [FUNC_W-1:0] FN_DEL_FRONT = 4'd4;
  localparam logic [FUNC_W-1:0] FN_DEL_POS   = 4'd5;
  localparam logic [FUNC_W-1:0] FN_SEARCH    = 4'd6;
  localparam logic [FUNC_W-1:0] FN_ROTATE    = 4'd7;
  localparam logic [FUNC_W-1:0] FN_LIST      = 4'd8;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] STAT_BADPOS   = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd4;

  // cell operations
  localparam int CELL_OP_W = 2;
  localparam logic [CELL_OP_W-1:0] CELL_HOLD  = 2'd0;
  localparam logic [CELL_OP_W-1:0] CELL_LOAD  = 2'd1;
  localparam logic [CELL_OP_W-1:0] CELL_LOWER = 2'd2;
  localparam logic [CELL_OP_W-1:0] CELL_UPPER = 2'd3;

  typedef struct packed {
    logic [CELL_OP_W-1:0] op;
    logic                 probe;
  } bale_cell_ctl_t;

  typedef struct packed {
    logic        [FUNC_W-1:0] func;
    logic signed [WORD_W-1:0] value;
    logic        [POS_W-1:0]  position;
    logic        [AMT_W-1:0]  amount;
  } bale_req_t;

  typedef struct packed {
    logic        [STAT_W-1:0]  status;
    logic signed [WORD_W-1:0]  word;
    logic        [INDEX_W-1:0] index;
    logic        [COUNT_W-1:0] count;
    logic                      last;
  } bale_rsp_t;

endpackage

// File: hdl/bale_cell.sv
// one list slot: holds a word, takes it from a neighbor, and compares it to a key
module bale_cell (
  input  logic                          clk,
  input  bale_pkg::bale_cell_ctl_t      ctl,
  input  logic signed [bale_pkg::WORD_W-1:0] value,
  input  logic signed [bale_pkg::WORD_W-1:0] lower,
  input  logic signed [bale_pkg::WORD_W-1:0] upper,
  output logic signed [bale_pkg::WORD_W-1:0] data,
  output logic                          hit
);
  import bale_pkg::*;

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_LOAD:  data <= value;
      CELL_LOWER: data <= lower;
      CELL_UPPER: data <= upper;
      default:    data <= data;
    endcase
    if (ctl.probe) begin
      hit <= (data == value);
    end
  end

endmodule

// File: hdl/bale_mod.sv
// bit-serial remainder of the rotate amount by the entry count
module bale_mod (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [bale_pkg::AMT_W-1:0]    amount,
  input  logic [bale_pkg::CNT_W-1:0]    divisor,
  output logic                          busy,
  output logic [bale_pkg::IDX_W-1:0]    rem
);
  import bale_pkg::*;

  logic [STEP_W-1:0] step;
  logic [AMT_W-1:0]  sh;
  logic [CNT_W-1:0]  r;
  logic [CNT_W-1:0]  d;
  logic [CNT_W:0]    trial;

  // shift in one amount bit, subtract the divisor if it fits
  assign trial = {r, sh[AMT_W-1]};
  assign rem   = IDX_W'(r);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && (step == STEP_W'(AMT_W - 1))) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step <= '0;
      sh   <= amount;
      r    <= '0;
      d    <= divisor;
    end else if (busy) begin
      step <= step + STEP_W'(1);
      sh   <= sh << 1;
      if (trial >= {1'b0, d}) begin
        r <= CNT_W'(trial - {1'b0, d});
      end else begin
        r <= trial[CNT_W-1:0];
      end
    end
  end

endmodule

// File: hdl/bounded_array_list_engine_top.sv
// bounded array list engine: top level with cell row, sequencer and result register
//
// Keeps an ordered list of up to CAPACITY (8) signed 32-bit words in a row of
// cells, one word per cell, each cell loading from the request or from its
// lower or upper neighbor. Inserts, deletes, full/empty/bad position results
// and unknown codes finish straight from idle: the whole row shifts in parallel.
// A search probes every cell at once, then steps over the hit flags one index
// a cycle while the output is not stalled, and gives the index of the first
// match, or not found on a miss. A rotate first runs a bit-serial remainder
// of the amount by the count, then moves the row right by one slot per cycle.
// A list gives one item per cycle while the output is not stalled, count
// items in all, the final one marked last. One request is worked on at a
// time; the request side stalls while a request is in progress or while a
// result waits on a stalled output. Results leave through a single output
// register.
module bounded_array_list_engine_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  bale_pkg::bale_req_t req_item,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output bale_pkg::bale_rsp_t rsp_item
);
  import bale_pkg::*;

`include "bounded_array_list_engine_top_macros.svh"

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_MOD    = 3'd2;
  localparam logic [2:0] S_ROT    = 3'd3;
  localparam logic [2:0] S_LIST   = 3'd4;

  logic [2:0]        state, state_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic [IDX_W-1:0]  rot_left, rot_left_next;

  logic              free;
  logic              accept;
  logic              load;
  bale_rsp_t         res;

  logic signed [WORD_W-1:0] words [CAPACITY];
  logic [CAPACITY-1:0]      hits;
  bale_cell_ctl_t           ctl [CAPACITY];
  logic signed [WORD_W-1:0] tail_word;

  logic              mod_start;
  logic              mod_busy;
  logic [IDX_W-1:0]  mod_rem;

  // request decode
  logic              full;
  logic              ins_ok, del_ok;
  logic              do_ins, do_del, do_probe, do_rot;
  logic [CNT_W-1:0]  ins_pos, del_pos;
  logic [CMP_W-1:0]  pos_c, cnt_c;
  logic [CNT_W-1:0]  cnt_m1;

  // output register frees up when empty or being taken this cycle
  assign free      = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE) || !free;
  assign accept    = req_valid && !req_stall;

  assign cnt_m1    = cnt - CNT_W'(1);
  assign tail_word = words[cnt_m1[IDX_W-1:0]];
  assign full      = (cnt >= CNT_W'(CAPACITY));
  assign pos_c     = CMP_W'(req_item.position);
  assign cnt_c     = CMP_W'(cnt);

  always_comb begin
    ins_pos = cnt;
    if (req_item.func == FN_INS_FRONT) begin
      ins_pos = '0;
    end else if (req_item.func == FN_INS_POS) begin
      ins_pos = CNT_W'(req_item.position);
    end
    del_pos = cnt_m1;
    if (req_item.func == FN_DEL_FRONT) begin
      del_pos = '0;
    end else if (req_item.func == FN_DEL_POS) begin
      del_pos = CNT_W'(req_item.position);
    end
  end

  assign ins_ok = !full && ((req_item.func != FN_INS_POS) || (pos_c <= cnt_c));
  assign del_ok = (cnt != '0) && ((req_item.func != FN_DEL_POS) || (pos_c < cnt_c));

  assign do_ins   = accept && (req_item.func inside {FN_INS_END, FN_INS_FRONT, FN_INS_POS})
                    && ins_ok;
  assign do_del   = accept && (req_item.func inside {FN_DEL_END, FN_DEL_FRONT, FN_DEL_POS})
                    && del_ok;
  assign do_probe = accept && (req_item.func == FN_SEARCH) && (cnt != '0);
  assign do_rot   = (state == S_ROT) && (rot_left != '0);

  // per-cell control: insert shifts up, delete shifts down, rotate wraps the tail
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctl[i].op    = CELL_HOLD;
      ctl[i].probe = do_probe;
      if (do_ins) begin
        if (CNT_W'(i) == ins_pos) begin
          ctl[i].op = CELL_LOAD;
        end else if ((CNT_W'(i) > ins_pos) && (CNT_W'(i) <= cnt)) begin
          ctl[i].op = CELL_LOWER;
        end
      end else if (do_del) begin
        if ((CNT_W'(i) >= del_pos) && (CNT_W'(i) < cnt_m1)) begin
          ctl[i].op = CELL_UPPER;
        end
      end else if (do_rot) begin
        if (CNT_W'(i) < cnt) begin
          ctl[i].op = CELL_LOWER;
        end
      end
    end
  end

  // row of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [WORD_W-1:0] lower_w, upper_w;
    if (g == 0) begin : g_head
      assign lower_w = tail_word;
    end else begin : g_mid
      assign lower_w = words[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign upper_w = words[g];
    end else begin : g_body
      assign upper_w = words[g+1];
    end
    bale_cell u_cell (
      .clk   (clk),
      .ctl   (ctl[g]),
      .value (req_item.value),
      .lower (lower_w),
      .upper (upper_w),
      .data  (words[g]),
      .hit   (hits[g])
    );
  end

  bale_mod u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (mod_start),
    .amount  (req_item.amount),
    .divisor (cnt),
    .busy    (mod_busy),
    .rem     (mod_rem)
  );

  // sequencer and result formation
  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    idx_next      = idx;
    rot_left_next = rot_left;
    load          = 1'b0;
    mod_start     = 1'b0;
    res           = '0;
    res.status    = STAT_OK;
    res.last      = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept) begin
          load = 1'b1;
          case (req_item.func) inside
            FN_INS_END, FN_INS_FRONT, FN_INS_POS: begin
              if (full) begin
                res.status = STAT_FULL;
              end else if (!ins_ok) begin
                res.status = STAT_BADPOS;
              end else begin
                cnt_next = cnt + CNT_W'(1);
              end
            end
            FN_DEL_END, FN_DEL_FRONT, FN_DEL_POS: begin
              if (cnt == '0) begin
                res.status = STAT_EMPTY;
              end else if (!del_ok) begin
                res.status = STAT_BADPOS;
              end else begin
                res.word = words[del_pos[IDX_W-1:0]];
                cnt_next = cnt_m1;
              end
            end
            FN_SEARCH, FN_ROTATE, FN_LIST: begin
              if (cnt == '0) begin
                res.status = STAT_EMPTY;
              end else begin
                load     = 1'b0;
                idx_next = '0;
                if (req_item.func == FN_SEARCH) begin
                  state_next = S_SCAN;
                end else if (req_item.func == FN_ROTATE) begin
                  mod_start  = 1'b1;
                  state_next = S_MOD;
                end else begin
                  state_next = S_LIST;
                end
              end
            end
            default: begin
              // unknown code: plain ok, list untouched
            end
          endcase
        end
      end
      S_SCAN: begin
        if (free) begin
          if (hits[idx]) begin
            load       = 1'b1;
            res.index  = INDEX_W'(idx);
            state_next = S_IDLE;
          end else if (CNT_W'(idx) == cnt_m1) begin
            load       = 1'b1;
            res.status = STAT_NOTFOUND;
            state_next = S_IDLE;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end
      S_MOD: begin
        if (!mod_busy) begin
          rot_left_next = mod_rem;
          state_next    = S_ROT;
        end
      end
      S_ROT: begin
        if (rot_left != '0) begin
          rot_left_next = rot_left - IDX_W'(1);
        end else if (free) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_LIST: begin
        if (free) begin
          load      = 1'b1;
          res.word  = words[idx];
          res.index = INDEX_W'(idx);
          res.last  = (CNT_W'(idx) == cnt_m1);
          if (res.last) begin
            state_next = S_IDLE;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    res.count = COUNT_W'(cnt_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    rot_left <= rot_left_next;
    if (load) begin
      rsp_item <= res;
    end
  end

  // entry count stays within capacity
  `BALE_ASSERT(a_cnt_range, cnt <= CNT_W'(CAPACITY), "entry count above capacity")
  // only a list gives results without the last mark
  `BALE_ASSERT(a_not_last_list, (rsp_valid && !rsp_item.last) |-> (state == S_LIST),
               "unmarked result outside a list")
  // an accepted item either has its result waiting or keeps the sequencer busy
  `BALE_ASSERT(a_accept_progress, accept |=> (rsp_valid || (state != S_IDLE)),
               "accepted item left no trace")
  // the rotation step count is a remainder of the count
  `BALE_ASSERT(a_rot_bound, (state == S_ROT) |-> (CNT_W'(rot_left) < cnt),
               "rotation steps not below count")
  // reset leaves no result and an idle sequencer
  `BALE_ASSERT_ALWAYS(a_reset_clear, rst |=> (!rsp_valid && (state == S_IDLE)),
                      "state not cleared by reset")

endmodule
